@@ src/pts_pkg.sv @@
// Shared types, constants and helpers of the pixel tone stretch curve.
`default_nettype none

package pts_pkg;

    localparam int PIXEL_BITS_DEF = 16;

    // Internal values are Q24 and may reach 1.0 itself, hence one extra bit.
    localparam int Q_BITS   = 24;
    localparam int X_W      = Q_BITS + 1;
    localparam int E_W      = 19;
    localparam int EM_W     = 17;
    localparam int L_W      = 21;
    localparam int ED_W     = 18;
    localparam int MD_W     = 41;
    localparam int SQ_STEPS = 16;
    localparam int APB_AW   = 5;

    localparam logic [X_W-1:0] Q_ONE   = 25'h100_0000;
    localparam logic [X_W-1:0] Q_HALF  = 25'h080_0000;
    localparam logic [23:0]    LN2_Q24 = 24'd11629080;

    // 2^-1/2, 2^-1/4, 2^-1/8 and 2^-1/16 in Q24.
    localparam logic [23:0] ROOT_TAB [4] = '{
        24'd11863283, 24'd14107901, 24'd15384775, 24'd16065917
    };

    localparam logic signed [17:0] ADJ_THR = 18'sd65;

    localparam logic [15:0] BLACK_RST = 16'd0;
    localparam logic [15:0] MID_RST   = 16'd32768;
    localparam logic [17:0] ADJ_RST   = 18'd0;
    localparam logic [16:0] BLEND_RST = 17'd32768;

    typedef enum logic [2:0] {
        REG_BLACK  = 3'd0,
        REG_MID    = 3'd1,
        REG_SHADOW = 3'd2,
        REG_HIGH   = 3'd3,
        REG_BLEND  = 3'd4
    } t_reg_idx;

    typedef struct packed {
        logic [X_W-1:0]  x;
        logic            lift;
        logic            crush;
        logic [EM_W-1:0] e_main;
        logic [EM_W-1:0] e_hx;
    } t_sh_side;

    typedef struct packed {
        logic [X_W-1:0]  x;
        logic [EM_W-1:0] e_hx;
    } t_mp_side;

    typedef struct packed {
        logic [X_W-1:0]  pw;
        logic [EM_W-1:0] e_hx;
        logic            zero;
    } t_md_side;

    typedef struct packed {
        logic [X_W-1:0] res;
        logic           apply;
    } t_hi_side;

    // Q24 product of a value and a table constant, truncated.
    function automatic logic [X_W-1:0] root_mul(logic [X_W-1:0] v, logic [23:0] c);
        logic [48:0] p;
        p = v * c;
        return p[48:24];
    endfunction

endpackage

`default_nettype wire

@@ src/pts_if.sv @@
// Request channels for input pixels and stretched output pixels.
`default_nettype none

interface pts_in_if #(
    parameter int PIXEL_BITS = pts_pkg::PIXEL_BITS_DEF
) ();
    logic                  valid;
    logic                  ready;
    logic [PIXEL_BITS-1:0] pixel_in;

    modport source (output valid, output pixel_in, input ready);
    modport sink   (input valid, input pixel_in, output ready);
endinterface

interface pts_out_if #(
    parameter int PIXEL_BITS = pts_pkg::PIXEL_BITS_DEF
) ();
    logic                  valid;
    logic                  ready;
    logic [PIXEL_BITS-1:0] pixel_out;

    modport source (output valid, output pixel_out, input ready);
    modport sink   (input valid, input pixel_out, output ready);
endinterface

`default_nettype wire

@@ src/pts_div.sv @@
// Pipelined restoring divider: quotient floor(num * 2^QB / den) for num <= den.
`default_nettype none

module pts_div #(
    parameter int W    = 25,
    parameter int QB   = 24,
    parameter int SB_W = 1
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_en,
    input  logic            i_valid,
    input  logic [W-1:0]    i_num,
    input  logic [W-1:0]    i_den,
    input  logic [SB_W-1:0] i_sb,
    output logic            o_valid,
    output logic [QB:0]     o_quo,
    output logic [SB_W-1:0] o_sb
);

    localparam int NST = QB + 1;
    localparam int QW  = QB + 1;

    logic [NST-1:0]  r_vld;
    logic [W-1:0]    r_rem [NST];
    logic [W-1:0]    r_den [NST];
    logic [QW-1:0]   r_quo [NST];
    logic [SB_W-1:0] r_sb  [NST];
    logic [W-1:0]    n_rem [NST];
    logic [QW-1:0]   n_quo [NST];
    logic            w_b0;

    // The integer bit is set only when num equals den.
    assign w_b0     = i_num >= i_den;
    assign n_rem[0] = w_b0 ? (i_num - i_den) : i_num;
    assign n_quo[0] = QW'(w_b0);

    for (genvar k = 1; k < NST; k++) begin : g_step
        logic [W:0] w_r2;
        logic       w_b;
        assign w_r2     = {r_rem[k-1], 1'b0};
        assign w_b      = w_r2 >= {1'b0, r_den[k-1]};
        assign n_rem[k] = w_b ? W'(w_r2 - {1'b0, r_den[k-1]}) : W'(w_r2);
        assign n_quo[k] = {r_quo[k-1][QB-1:0], w_b};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[NST-2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0] <= n_rem[0];
            r_den[0] <= i_den;
            r_quo[0] <= n_quo[0];
            r_sb[0]  <= i_sb;
            for (int k = 1; k < NST; k++) begin
                r_rem[k] <= n_rem[k];
                r_den[k] <= r_den[k-1];
                r_quo[k] <= n_quo[k];
                r_sb[k]  <= r_sb[k-1];
            end
        end
    end

    assign o_valid = r_vld[NST-1];
    assign o_quo   = r_quo[NST-1];
    assign o_sb    = r_sb[NST-1];

endmodule

`default_nettype wire

@@ src/pts_pow.sv @@
// Pipelined Q24 power x^e through a squaring log2 and a table based exp2.
`default_nettype none

module pts_pow #(
    parameter int SB_W = 1
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_en,
    input  logic                      i_valid,
    input  logic [pts_pkg::X_W-1:0]   i_x,
    input  logic [pts_pkg::E_W-1:0]   i_e,
    input  logic [SB_W-1:0]           i_sb,
    output logic                      o_valid,
    output logic [pts_pkg::X_W-1:0]   o_y,
    output logic [SB_W-1:0]           o_sb
);

    localparam int NS    = pts_pkg::SQ_STEPS;
    localparam int DEPTH = NS + 8;
    localparam int TW    = SB_W + 2;
    localparam int XW    = pts_pkg::X_W;
    localparam int EW    = pts_pkg::E_W;
    localparam int QB    = pts_pkg::Q_BITS;
    localparam int L_W_C = pts_pkg::L_W;

    logic [DEPTH-1:0] r_vld;
    // Tag = {x is zero, result is one, sideband}.
    logic [TW-1:0]    r_tag [DEPTH-1];

    // Normalize and squaring stages.
    logic [QB-1:0]    r_m [NS+1];
    logic [NS-1:0]    r_f [NS+1];
    logic [4:0]       r_p [NS+1];
    logic [EW-1:0]    r_e [NS+1];
    logic [QB-1:0]    n_m [NS+1];
    logic [NS-1:0]    n_f [NS+1];
    logic [4:0]       n_p0;

    // Exponent product and exp2 stages.
    logic [23:0]      r_y;
    logic [XW-1:0]    r_v1, r_v2, r_v3, r_v4, r_v5;
    logic [19:0]      r_a1, r_a2;
    logic [14:0]      r_asq2;
    logic [XW-1:0]    r_poly3, r_poly4;
    logic [2:0]       r_rb1;
    logic [1:0]       r_rb2;
    logic             r_rb3;
    logic [5:0]       r_nb [5];
    logic [XW-1:0]    r_out;

    logic             w_zero, w_one;
    logic [L_W_C-1:0] w_l;
    logic [39:0]      w_ly;
    logic [35:0]      w_ap;
    logic [39:0]      w_asq;
    logic [48:0]      w_vp;
    logic [XW-1:0]    n_v1;
    logic [XW-1:0]    w_shr;

    always_comb begin
        n_p0 = '0;
        for (int i = 0; i < QB; i++) begin
            if (i_x[i]) begin
                n_p0 = 5'(i);
            end
        end
    end

    assign n_m[0]  = QB'(i_x[QB-1:0] << (5'd23 - n_p0));
    assign n_f[0]  = '0;
    assign w_zero  = i_x == '0;
    assign w_one   = i_x[QB] || (i_e == '0);

    // Each step squares the mantissa; an overflow past 2.0 is the next log bit.
    for (genvar k = 1; k <= NS; k++) begin : g_sq
        logic [2*QB-1:0] w_sq;
        logic [QB:0]     w_t;
        assign w_sq   = r_m[k-1] * r_m[k-1];
        assign w_t    = w_sq[2*QB-1:QB-1];
        assign n_m[k] = w_t[QB] ? w_t[QB:1] : w_t[QB-1:0];
        assign n_f[k] = {r_f[k-1][NS-2:0], w_t[QB]};
    end

    assign w_l   = {5'd24 - r_p[NS], 16'd0} - L_W_C'(r_f[NS]);
    assign w_ly  = w_l * r_e[NS];
    assign w_ap  = r_y[11:0] * pts_pkg::LN2_Q24;
    assign n_v1  = r_y[15] ? {1'b0, pts_pkg::ROOT_TAB[0]} : pts_pkg::Q_ONE;
    assign w_asq = r_a1 * r_a1;
    assign w_vp  = r_v4 * r_poly4;
    assign w_shr = r_v5 >> r_nb[4][4:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[DEPTH-2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_tag[0] <= {w_zero, w_one, i_sb};
            for (int k = 1; k < DEPTH - 1; k++) begin
                r_tag[k] <= r_tag[k-1];
            end

            r_m[0] <= n_m[0];
            r_f[0] <= n_f[0];
            r_p[0] <= n_p0;
            r_e[0] <= i_e;
            for (int k = 1; k <= NS; k++) begin
                r_m[k] <= n_m[k];
                r_f[k] <= n_f[k];
                r_p[k] <= r_p[k-1];
                r_e[k] <= r_e[k-1];
            end

            r_y <= w_ly[39:16];

            r_v1     <= n_v1;
            r_a1     <= w_ap[35:16];
            r_rb1    <= r_y[14:12];
            r_nb[0]  <= {r_y[23:16] >= 8'd25, r_y[20:16]};

            r_v2     <= r_rb1[2] ? pts_pkg::root_mul(r_v1, pts_pkg::ROOT_TAB[1]) : r_v1;
            r_a2     <= r_a1;
            r_asq2   <= w_asq[39:25];
            r_rb2    <= r_rb1[1:0];

            r_v3     <= r_rb2[1] ? pts_pkg::root_mul(r_v2, pts_pkg::ROOT_TAB[2]) : r_v2;
            r_poly3  <= pts_pkg::Q_ONE - XW'(r_a2) + XW'(r_asq2);
            r_rb3    <= r_rb2[0];

            r_v4     <= r_rb3 ? pts_pkg::root_mul(r_v3, pts_pkg::ROOT_TAB[3]) : r_v3;
            r_poly4  <= r_poly3;

            r_v5     <= w_vp[48:24];

            for (int k = 1; k < 5; k++) begin
                r_nb[k] <= r_nb[k-1];
            end

            if (r_tag[DEPTH-2][TW-1]) begin
                r_out <= '0;
            end else if (r_tag[DEPTH-2][TW-2]) begin
                r_out <= pts_pkg::Q_ONE;
            end else if (r_nb[4][5]) begin
                r_out <= '0;
            end else begin
                r_out <= w_shr;
            end
            o_sb <= r_tag[DEPTH-2][SB_W-1:0];
        end
    end

    assign o_valid = r_vld[DEPTH-1];
    assign o_y     = r_out;

endmodule

`default_nettype wire

@@ src/pixel_tone_stretch_curve.sv @@
// Top level of the pixel tone stretch curve: register port and pixel pipeline.
//
// One pixel enters per cycle on i_pix and one stretched pixel leaves on
// o_pix for each, in order. A pixel is a request on either channel when
// valid and ready are both high at a rising edge of i_clk.
// The pipeline is 126 register stages: the rescale divider (25 stages),
// the shadow, midtones and highlight power units (24 stages each), the
// midtones transfer divider (25 stages) and four product and output
// registers. Throughput is one pixel per cycle, since every divider bit
// and every squaring step has its own stage.
// When the receiver holds o_pix.ready low while a result waits, the whole
// pipeline holds and i_pix.ready falls; nothing is lost or repeated.
// The five settings are written over the APB port. The user must write
// them only while no pixel is in flight; the block does not enforce it.
// A synchronous low i_rst_n empties the pipeline and returns the settings
// to their defaults; no pixel is needed to flush anything.
`default_nettype none

module pixel_tone_stretch_curve #(
    parameter int PIXEL_BITS = pts_pkg::PIXEL_BITS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    pts_in_if.sink                         i_pix,
    pts_out_if.source                      o_pix,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [pts_pkg::APB_AW-1:0]     paddr,
    input  logic [31:0]                    pwdata,
    output logic [31:0]                    prdata,
    output logic                           pready
);

    localparam int XW  = pts_pkg::X_W;
    localparam int EW  = pts_pkg::E_W;
    localparam int MW  = pts_pkg::MD_W;
    localparam int DW  = pts_pkg::ED_W;
    localparam int SH  = pts_pkg::Q_BITS - PIXEL_BITS;
    localparam logic [XW-1:0] PMAX = XW'((64'd1 << PIXEL_BITS) - 64'd1);

    // Settings.
    logic [15:0] r_black;
    logic [15:0] r_mid;
    logic [17:0] r_shadow;
    logic [17:0] r_high;
    logic [16:0] r_blend;
    logic        w_wr;

    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_black  <= pts_pkg::BLACK_RST;
            r_mid    <= pts_pkg::MID_RST;
            r_shadow <= pts_pkg::ADJ_RST;
            r_high   <= pts_pkg::ADJ_RST;
            r_blend  <= pts_pkg::BLEND_RST;
        end else if (w_wr) begin
            case (pts_pkg::t_reg_idx'(paddr[4:2]))
                pts_pkg::REG_BLACK:  r_black  <= pwdata[15:0];
                pts_pkg::REG_MID:    r_mid    <= pwdata[15:0];
                pts_pkg::REG_SHADOW: r_shadow <= pwdata[17:0];
                pts_pkg::REG_HIGH:   r_high   <= pwdata[17:0];
                pts_pkg::REG_BLEND:  r_blend  <= pwdata[16:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        prdata = '0;
        case (pts_pkg::t_reg_idx'(paddr[4:2]))
            pts_pkg::REG_BLACK:  prdata = 32'(r_black);
            pts_pkg::REG_MID:    prdata = 32'(r_mid);
            pts_pkg::REG_SHADOW: prdata = 32'(r_shadow);
            pts_pkg::REG_HIGH:   prdata = 32'(r_high);
            pts_pkg::REG_BLEND:  prdata = 32'(r_blend);
            default:             prdata = '0;
        endcase
    end

    // Derived settings.
    logic signed [17:0] w_s, w_h;
    logic               w_lift, w_crush, w_h_act;
    logic [18:0]        w_lift_sum, w_crush_e, w_hneg, w_comp_e;
    logic [16:0]        w_c;

    assign w_s        = signed'(r_shadow);
    assign w_h        = signed'(r_high);
    assign w_lift     = w_s < -pts_pkg::ADJ_THR;
    assign w_crush    = w_s > pts_pkg::ADJ_THR;
    assign w_h_act    = (w_h < -pts_pkg::ADJ_THR) || (w_h > pts_pkg::ADJ_THR);
    assign w_lift_sum = 19'h2_0000 + 19'(w_s);
    assign w_crush_e  = 19'h1_0000 + {1'b0, w_s[16:0], 1'b0};
    assign w_hneg     = 19'h0 - 19'(w_h);
    assign w_comp_e   = 19'h1_0000 + (w_hneg >> 1);
    assign w_c        = (r_blend > 17'h1_0000) ? 17'h1_0000 : r_blend;

    // Global advance: the pipeline moves unless a result waits at the output.
    logic              r_out_vld;
    logic [PIXEL_BITS-1:0] r_out_pix;
    logic              w_en;

    assign w_en        = !r_out_vld || o_pix.ready;
    assign i_pix.ready = w_en;

    // Rescale and exponent dividers, side by side.
    logic [XW-1:0] w_v, w_bp, w_num, w_den;
    logic [DW-1:0] w_dm_den, w_dh_den;
    logic [XW-1:0] w_dx_q, w_dm_q, w_dh_q;
    logic          w_dx_vld;

    assign w_v      = XW'(i_pix.pixel_in) << SH;
    assign w_bp     = {1'b0, r_black, 8'h00};
    assign w_num    = (w_v > w_bp) ? (w_v - w_bp) : '0;
    assign w_den    = pts_pkg::Q_ONE - w_bp;
    assign w_dm_den = 18'h1_0000 + {2'b0, r_mid} + {1'b0, r_mid, 1'b0};
    assign w_dh_den = w_h[17] ? 18'h1_0000 : (18'h1_0000 + {2'b0, w_h[16:1]});

    pts_div #(.W(XW), .QB(pts_pkg::Q_BITS), .SB_W(1)) u_div_x (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(w_en), .i_valid(i_pix.valid),
        .i_num(w_num), .i_den(w_den), .i_sb(1'b0),
        .o_valid(w_dx_vld), .o_quo(w_dx_q), .o_sb()
    );

    pts_div #(.W(DW), .QB(pts_pkg::Q_BITS), .SB_W(1)) u_div_em (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(w_en), .i_valid(i_pix.valid),
        .i_num(18'h1_0000), .i_den(w_dm_den), .i_sb(1'b0),
        .o_valid(), .o_quo(w_dm_q), .o_sb()
    );

    pts_div #(.W(DW), .QB(pts_pkg::Q_BITS), .SB_W(1)) u_div_eh (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(w_en), .i_valid(i_pix.valid),
        .i_num(18'h1_0000), .i_den(w_dh_den), .i_sb(1'b0),
        .o_valid(), .o_quo(w_dh_q), .o_sb()
    );

    // Shadow power.
    pts_pkg::t_sh_side w_sh_in, w_sh_out;
    logic [XW-1:0]     w_sh_x, w_sh_y, w_x1;
    logic [EW-1:0]     w_sh_e;
    logic              w_sh_vld;

    always_comb begin
        w_sh_in.x      = w_dx_q;
        w_sh_in.lift   = w_lift;
        w_sh_in.crush  = w_crush && (w_dx_q < pts_pkg::Q_HALF);
        w_sh_in.e_main = w_dm_q[24:8];
        w_sh_in.e_hx   = w_dh_q[24:8];
    end

    assign w_sh_x = w_crush ? {w_dx_q[23:0], 1'b0} : w_dx_q;
    assign w_sh_e = w_lift ? EW'(w_lift_sum[17:1]) : w_crush_e;

    pts_pow #(.SB_W($bits(pts_pkg::t_sh_side))) u_pow_sh (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(w_en), .i_valid(w_dx_vld),
        .i_x(w_sh_x), .i_e(w_sh_e), .i_sb(w_sh_in),
        .o_valid(w_sh_vld), .o_y(w_sh_y), .o_sb(w_sh_out)
    );

    assign w_x1 = w_sh_out.lift  ? w_sh_y :
                  w_sh_out.crush ? {1'b0, w_sh_y[24:1]} : w_sh_out.x;

    // Power curve of the midtones blend.
    pts_pkg::t_mp_side w_mp_in, w_mp_out;
    logic [XW-1:0]     w_pw;
    logic              w_mp_vld;

    always_comb begin
        w_mp_in.x    = w_x1;
        w_mp_in.e_hx = w_sh_out.e_hx;
    end

    pts_pow #(.SB_W($bits(pts_pkg::t_mp_side))) u_pow_mp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(w_en), .i_valid(w_sh_vld),
        .i_x(w_x1), .i_e(EW'(w_sh_out.e_main)), .i_sb(w_mp_in),
        .o_valid(w_mp_vld), .o_y(w_pw), .o_sb(w_mp_out)
    );

    // Transfer function operands.
    logic              r_p1_vld;
    logic [MW-1:0]     r_p1_num, r_p1_mq;
    pts_pkg::t_md_side r_p1_side;
    logic [16:0]       w_wm;

    assign w_wm = 17'h1_0000 - {1'b0, r_mid};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p1_vld <= 1'b0;
        end else if (w_en) begin
            r_p1_vld <= w_mp_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_p1_num       <= MW'(w_wm) * MW'(w_mp_out.x);
            r_p1_mq        <= MW'(r_mid) * MW'(pts_pkg::Q_ONE - w_mp_out.x);
            r_p1_side.pw   <= w_pw;
            r_p1_side.e_hx <= w_mp_out.e_hx;
            r_p1_side.zero <= w_mp_out.x == '0;
        end
    end

    // A zero input would give a zero divisor when the balance is zero.
    logic [MW-1:0]     w_md_den;
    logic [XW-1:0]     w_md_q, w_mt;
    pts_pkg::t_md_side w_md_out;
    logic              w_md_vld;

    assign w_md_den = r_p1_side.zero ? MW'(1) : (r_p1_num + r_p1_mq);

    pts_div #(.W(MW), .QB(pts_pkg::Q_BITS), .SB_W($bits(pts_pkg::t_md_side))) u_div_mt (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(w_en), .i_valid(r_p1_vld),
        .i_num(r_p1_num), .i_den(w_md_den), .i_sb(r_p1_side),
        .o_valid(w_md_vld), .o_quo(w_md_q), .o_sb(w_md_out)
    );

    assign w_mt = w_md_out.zero ? '0 : w_md_q;

    // Blend of the two curves.
    logic          r_b1_vld, r_b2_vld;
    logic [MW-1:0] r_b1_p1, r_b1_p2;
    logic [16:0]   r_b1_ehx;
    logic [MW-1:0] w_bsum;
    logic [XW-1:0] w_res;
    logic [XW-1:0] r_b2_res;
    logic          r_b2_apply;
    logic [EW-1:0] r_b2_e;

    assign w_bsum = r_b1_p1 + r_b1_p2;
    assign w_res  = w_bsum[40:16];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b1_vld <= 1'b0;
            r_b2_vld <= 1'b0;
        end else if (w_en) begin
            r_b1_vld <= w_md_vld;
            r_b2_vld <= r_b1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_b1_p1    <= MW'(w_mt) * MW'(17'h1_0000 - w_c);
            r_b1_p2    <= MW'(w_md_out.pw) * MW'(w_c);
            r_b1_ehx   <= w_md_out.e_hx;
            r_b2_res   <= w_res;
            r_b2_apply <= w_h_act && (w_res > pts_pkg::Q_HALF);
            r_b2_e     <= w_h[17] ? w_comp_e : EW'(r_b1_ehx);
        end
    end

    // Highlight power on the upper half.
    pts_pkg::t_hi_side w_hi_in, w_hi_out;
    logic [XW-1:0]     w_hi_x, w_hi_y, w_fin, w_shf;
    logic              w_hi_vld;

    always_comb begin
        w_hi_in.res   = r_b2_res;
        w_hi_in.apply = r_b2_apply;
    end

    assign w_hi_x = XW'({r_b2_res - pts_pkg::Q_HALF, 1'b0});

    pts_pow #(.SB_W($bits(pts_pkg::t_hi_side))) u_pow_hi (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(w_en), .i_valid(r_b2_vld),
        .i_x(w_hi_x), .i_e(r_b2_e), .i_sb(w_hi_in),
        .o_valid(w_hi_vld), .o_y(w_hi_y), .o_sb(w_hi_out)
    );

    assign w_fin = w_hi_out.apply ? (pts_pkg::Q_HALF + {1'b0, w_hi_y[24:1]}) : w_hi_out.res;
    assign w_shf = w_fin >> SH;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_en) begin
            r_out_vld <= w_hi_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_out_pix <= (w_shf > PMAX) ? PIXEL_BITS'(PMAX) : PIXEL_BITS'(w_shf);
        end
    end

    assign o_pix.valid     = r_out_vld;
    assign o_pix.pixel_out = r_out_pix;

endmodule

`default_nettype wire

@@ bench/tb_pixel_tone_stretch_curve.sv @@
// Self-checking testbench for the pixel tone stretch curve pipeline.
`default_nettype none

module tb_pixel_tone_stretch_curve;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int PB         = 16;
    localparam int AW         = pts_pkg::APB_AW;
    localparam int LATENCY    = 126;
    localparam int N_RANDOM   = 2000;
    localparam int CYCLE_CAP  = 1000000;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [AW-1:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic pready;

    pts_in_if  #(.PIXEL_BITS(PB)) pix_in ();
    pts_out_if #(.PIXEL_BITS(PB)) pix_out ();

    pixel_tone_stretch_curve #(.PIXEL_BITS(PB)) u_top (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_pix(pix_in.sink), .o_pix(pix_out.source),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    always #10 i_clk = ~i_clk;

    // Settings as the predictor sees them.
    logic [15:0] set_black, set_mid;
    logic [17:0] set_shadow, set_high;
    logic [16:0] set_blend;

    logic [PB-1:0] pixel_queue[$];
    logic [PB-1:0] expected_pixels[$];
    int  errors = 0;
    int  cycles = 0;
    bit  feeding = 1'b0;

    initial begin
        pix_in.valid = 1'b0;
        pix_in.pixel_in = '0;
        pix_out.ready = 1'b0;
    end

    // Gap length: mostly zero or short, now and then long.
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 93) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // -log2 of a Q24 value, Q16 result.
    function automatic logic [31:0] neg_log2_q(logic [31:0] x);
        int p;
        logic [63:0] m;
        logic [31:0] frac;
        p = 23;
        frac = 0;
        while (p > 0 && x[p] == 1'b0) p--;
        m = 64'(x) << (23 - p);
        for (int k = 0; k < 16; k++) begin
            m = (m * m) >> 23;
            frac = frac << 1;
            if (m >= 64'(pts_pkg::Q_ONE)) begin
                frac[0] = 1'b1;
                m = m >> 1;
            end
        end
        return 32'(24 - p) * 32'd65536 - frac;
    endfunction

    function automatic logic [31:0] exp2_neg_q(logic [63:0] y);
        logic [63:0] n, r, v, a, poly;
        n = y >> 16;
        r = y & 64'hFFFF;
        v = 64'(pts_pkg::Q_ONE);
        if (n >= 25) return 0;
        for (int k = 0; k < 4; k++)
            if (r[15-k]) v = (v * 64'(pts_pkg::ROOT_TAB[k])) >> 24;
        a = ((r & 64'h0FFF) * 64'(pts_pkg::LN2_Q24)) >> 16;
        poly = 64'(pts_pkg::Q_ONE) - a + ((a * a) >> 25);
        v = (v * poly) >> 24;
        return 32'(v >> n);
    endfunction

    function automatic logic [31:0] power_q(logic [31:0] x, logic [31:0] e);
        if (x == 0) return 0;
        if (x >= 32'(pts_pkg::Q_ONE) || e == 0) return 32'(pts_pkg::Q_ONE);
        return exp2_neg_q((64'(neg_log2_q(x)) * 64'(e)) >> 16);
    endfunction

    function automatic logic [31:0] mtf_q(logic [31:0] x, logic [31:0] m);
        logic [63:0] num, den, q1, r1, q2;
        if (x == 0) return 0;
        if (x >= 32'(pts_pkg::Q_ONE)) return 32'(pts_pkg::Q_ONE);
        num = 64'(32'd65536 - m) * 64'(x);
        den = 64'(m) * 64'(32'(pts_pkg::Q_ONE) - x) + num;
        q1 = (num << 12) / den;
        r1 = (num << 12) % den;
        q2 = (r1 << 12) / den;
        return 32'((q1 << 12) | q2);
    endfunction

    function automatic logic [PB-1:0] stretch_pixel(logic [PB-1:0] pin);
        logic [31:0] v, bp, m, c, x, mt, pw, e, res;
        int s, h;
        v = 32'(pin) << (24 - PB);
        bp = 32'(set_black) << 8;
        m = 32'(set_mid);
        s = int'($signed(set_shadow));
        h = int'($signed(set_high));
        c = (set_blend > 17'd65536) ? 32'd65536 : 32'(set_blend);
        if (v <= bp) return '0;
        x = 32'((64'(v - bp) << 24) / 64'(32'(pts_pkg::Q_ONE) - bp));
        if (x == 0) return '0;
        if (s < -65) begin
            e = 32'(131072 + s) >> 1;
            x = power_q(x, e);
        end else if (s > 65) begin
            e = 32'd65536 + 32'(2 * s);
            if (x < 32'(pts_pkg::Q_HALF)) x = power_q(x * 2, e) >> 1;
        end
        mt = mtf_q(x, m);
        pw = power_q(x, 32'(64'h1_0000_0000 / 64'(32'd65536 + 3 * m)));
        res = 32'((64'(mt) * 64'(32'd65536 - c) + 64'(pw) * 64'(c)) >> 16);
        if (h < -65 || h > 65) begin
            if (h < 0) e = 32'd65536 + (32'(-h) >> 1);
            else e = 32'(64'h1_0000_0000 / 64'(32'd65536 + (32'(h) >> 1)));
            if (res > 32'(pts_pkg::Q_HALF))
                res = 32'(pts_pkg::Q_HALF)
                      + (power_q((res - 32'(pts_pkg::Q_HALF)) * 2, e) >> 1);
        end
        res = res >> (24 - PB);
        if (res > 32'((1 << PB) - 1)) res = 32'((1 << PB) - 1);
        return PB'(res);
    endfunction

    task automatic write_setting(pts_pkg::t_reg_idx idx, logic [31:0] value);
        @(posedge i_clk);
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
        paddr <= AW'(4 * int'(idx)); pwdata <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        case (idx)
            pts_pkg::REG_BLACK:  set_black = value[15:0];
            pts_pkg::REG_MID:    set_mid = value[15:0];
            pts_pkg::REG_SHADOW: set_shadow = value[17:0];
            pts_pkg::REG_HIGH:   set_high = value[17:0];
            pts_pkg::REG_BLEND:  set_blend = value[16:0];
            default: ;
        endcase
    endtask

    task automatic apply_settings(logic [15:0] b, logic [15:0] m, int s, int h,
                                  logic [16:0] c);
        write_setting(pts_pkg::REG_BLACK, 32'(b));
        write_setting(pts_pkg::REG_MID, 32'(m));
        write_setting(pts_pkg::REG_SHADOW, 32'(s));
        write_setting(pts_pkg::REG_HIGH, 32'(h));
        write_setting(pts_pkg::REG_BLEND, 32'(c));
    endtask

    // Lets the queued pixels run through, then waits for the pipeline to drain.
    task automatic run_phase();
        feeding = 1'b1;
        wait (pixel_queue.size() == 0);
        feeding = 1'b0;
        wait (expected_pixels.size() == 0);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic queue_directed();
        logic [PB-1:0] vals[$];
        vals = '{16'd0, 16'd1, 16'd2, 16'hFFFF, 16'hFFFE, 16'h8000, 16'h7FFF,
                 16'h4000, 16'hC000, 16'h0100, 16'h5555, 16'hAAAA};
        foreach (vals[i]) pixel_queue.push_back(vals[i]);
    endtask

    task automatic queue_random(int n, logic [15:0] black);
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(0, 9) == 0)
                pixel_queue.push_back(PB'($urandom_range(0, black)));
            else
                pixel_queue.push_back(PB'($urandom()));
        end
    endtask

    // Driver: presents queued pixels with random gaps. The head of the queue
    // is the pixel on the bus until it is accepted.
    int drive_gap = 0;
    always @(posedge i_clk) begin
        if (pix_in.valid && pix_in.ready) begin
            expected_pixels.push_back(stretch_pixel(pix_in.pixel_in));
            void'(pixel_queue.pop_front());
        end
        if (!pix_in.valid || pix_in.ready) begin
            if (drive_gap > 0 || !feeding) begin
                drive_gap <= drive_gap > 0 ? drive_gap - 1 : 0;
                pix_in.valid <= 1'b0;
            end else if (pixel_queue.size() > 0) begin
                pix_in.valid <= 1'b1;
                pix_in.pixel_in <= pixel_queue[0];
                drive_gap <= gap_len();
            end else begin
                pix_in.valid <= 1'b0;
            end
        end
    end

    // Monitor: random backpressure and in-order comparison.
    int stall = 0;
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (i_rst_n && pix_out.valid && pix_out.ready) begin
            if (expected_pixels.size() == 0) begin
                $display("%0t: unexpected pixel_out %0d", $time, pix_out.pixel_out);
                errors <= errors + 1;
            end else begin
                if (pix_out.pixel_out !== expected_pixels[0]) begin
                    $display("%0t: pixel_out expected %0d actual %0d", $time,
                             expected_pixels[0], pix_out.pixel_out);
                    errors <= errors + 1;
                end
                void'(expected_pixels.pop_front());
            end
        end
        if (stall > 0) begin
            stall <= stall - 1;
            pix_out.ready <= 1'b0;
        end else begin
            stall <= gap_len();
            pix_out.ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        if (cycles > CYCLE_CAP) begin
            $display("Some tests failed");
            $finish;
        end
    end

    initial begin
        int b, per_phase;
        set_black = pts_pkg::BLACK_RST; set_mid = pts_pkg::MID_RST;
        set_shadow = pts_pkg::ADJ_RST; set_high = pts_pkg::ADJ_RST;
        set_blend = pts_pkg::BLEND_RST;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Defaults after reset, then the corners of every setting.
        queue_directed();
        run_phase();
        apply_settings(16'd32768, 16'd7, -65536, 65536, 17'd0);
        queue_directed();
        run_phase();
        apply_settings(16'd0, 16'd65529, 65536, -65536, 17'd65536);
        queue_directed();
        run_phase();
        apply_settings(16'd100, 16'd0, 65, -65, 17'h1FFFF);
        queue_directed();
        run_phase();
        apply_settings(16'hFFFF, 16'hFFFF, 66, -66, 17'd65537);
        queue_directed();
        run_phase();

        per_phase = N_RANDOM / 10;
        for (int ph = 0; ph < 10; ph++) begin
            b = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 32768);
            apply_settings(16'(b), 16'($urandom_range(7, 65529)),
                           $urandom_range(0, 3) == 0 ? 0 : int'($urandom_range(0, 131072)) - 65536,
                           $urandom_range(0, 3) == 0 ? 0 : int'($urandom_range(0, 131072)) - 65536,
                           17'($urandom_range(0, 65536)));
            queue_random(per_phase, 16'(b));
            run_phase();
        end

        repeat (LATENCY + 20) @(posedge i_clk);
        if (errors == 0 && expected_pixels.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

`default_nettype wire
